[rtl/core/srmp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Stepped speed ramp package
// Widths, limits, register indexes and the structs that pass between the
// ramp sequencer and the shared divide unit.
// ----------------------------------------------------------------------------
package srmp_pkg;

    // Field widths.
    localparam int SPEED_W = 8;
    localparam int STEP_W  = 7;
    localparam int FS_W    = 23;
    localparam int VEL_W   = 24;
    localparam int MAG_W   = 7;
    localparam int PROD_W  = MAG_W + FS_W;
    localparam int QUO_W   = 23;

    // Divide by one hundred as a divide by four followed by a multiplication
    // with 2^33 / 25 rounded up, exact for every 28-bit quarter product.
    localparam int DIVD_W      = PROD_W - 2;
    localparam int RECIP_W     = 29;
    localparam int RPROD_W     = DIVD_W + RECIP_W;
    localparam int RECIP_SHIFT = 33;
    localparam logic [RECIP_W-1:0] RECIP_25 = 29'd343597384;

    // Speed limits and thresholds.
    localparam logic signed [SPEED_W:0] SPEED_MAX = 9'sd100;
    localparam logic signed [SPEED_W:0] SPEED_MIN = -9'sd100;
    localparam logic [MAG_W-1:0]        SPREAD_LIMIT = 7'd20;
    localparam logic [STEP_W-1:0]       MIN_STEP = 7'd4;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0] STEP_SIZE_RST  = 7'd5;
    localparam logic [FS_W-1:0]   FULL_SCALE_RST = 23'd100000;

    // Configuration register indexes.
    localparam logic CFG_STEP_SIZE  = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    // Request to the divide unit: scale |speed| by full scale, then divide.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [FS_W-1:0]  scale;
    } div_req_t;

    // Response of the divide unit.
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

    // One motor command handed to the output register.
    typedef struct packed {
        logic             load;
        logic [VEL_W-1:0] velocity;
        logic             spread_cycle;
        logic             freewheel;
        logic             last;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/core/srmp_div100.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Shared scale-and-divide unit
// Multiplies a speed magnitude by the full scale value, then divides the
// product by one hundred with a reciprocal multiplication.
// ----------------------------------------------------------------------------
module srmp_div100 (
    input  wire                aclk,
    input  wire                aresetn,
    input  srmp_pkg::div_req_t req,
    output srmp_pkg::div_rsp_t rsp
);
    import srmp_pkg::*;

    logic               stage_reg;
    logic               done_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QUO_W-1:0]   quot_reg;

    logic [RPROD_W-1:0] recip_prod;

    // Drop the factor four, then multiply by the reciprocal of twenty-five.
    assign recip_prod = RPROD_W'(prod_reg[PROD_W-1:2]) * RPROD_W'(RECIP_25);

    // Control: the product stage, then the quotient stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= req.start;
            done_reg  <= stage_reg;
        end
    end

    // Datapath: scaled product first, quotient in the following cycle.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg <= PROD_W'(req.mag) * PROD_W'(req.scale);
        end
        if (stage_reg) begin
            quot_reg <= recip_prod[RECIP_SHIFT +: QUO_W];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
`default_nettype wire

[rtl/core/srmp_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Ramp sequencer
// Saturates the target, steps the held speed toward it, keeps the freewheel
// state and drives the divide unit once for every command it emits.
// ----------------------------------------------------------------------------
module srmp_seq (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire signed [srmp_pkg::SPEED_W-1:0] target_speed,
    input  wire        [srmp_pkg::STEP_W-1:0]  step_size,
    input  wire        [srmp_pkg::FS_W-1:0]    full_scale,
    output srmp_pkg::div_req_t                 div_req,
    input  srmp_pkg::div_rsp_t                 div_rsp,
    input  wire                                out_free,
    output srmp_pkg::cmd_t                     cmd
);
    import srmp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_PLAN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]                state_reg;
    logic signed [SPEED_W-1:0] held_reg;
    logic                      fw_reg;
    logic signed [SPEED_W-1:0] tgt_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic                      last_reg;

    logic signed [SPEED_W:0]   tgt_wide;
    logic signed [SPEED_W-1:0] tgt_sat;
    logic [STEP_W-1:0]         step_eff;
    logic signed [SPEED_W:0]   held_ext;
    logic signed [SPEED_W:0]   tgt_ext;
    logic signed [SPEED_W:0]   step_ext;
    logic signed [SPEED_W:0]   gap;
    logic                      go_up;
    logic                      go_dn;
    logic signed [SPEED_W:0]   spd_wide;
    logic signed [SPEED_W-1:0] spd;
    logic [SPEED_W-1:0]        spd_abs;
    logic [QUO_W:0]            quot_ext;
    logic                      accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Input saturation and the smallest usable step.
    always_comb begin
        tgt_wide = {target_speed[SPEED_W-1], target_speed};
        if (tgt_wide < SPEED_MIN) begin
            tgt_sat = SPEED_MIN[SPEED_W-1:0];
        end else if (tgt_wide > SPEED_MAX) begin
            tgt_sat = SPEED_MAX[SPEED_W-1:0];
        end else begin
            tgt_sat = target_speed;
        end
        step_eff = (step_size < MIN_STEP) ? MIN_STEP : step_size;
    end

    // Next speed of the ramp: one step up, one step down, or the target.
    always_comb begin
        held_ext = {held_reg[SPEED_W-1], held_reg};
        tgt_ext  = {tgt_reg[SPEED_W-1], tgt_reg};
        step_ext = $signed({2'b00, step_reg});
        gap      = tgt_ext - held_ext;
        go_up    = (gap > step_ext);
        go_dn    = (gap < -step_ext);
        if (go_up) begin
            spd_wide = held_ext + step_ext;
        end else if (go_dn) begin
            spd_wide = held_ext - step_ext;
        end else begin
            spd_wide = tgt_ext;
        end
        spd     = spd_wide[SPEED_W-1:0];
        spd_abs = spd[SPEED_W-1] ? SPEED_W'(-spd) : SPEED_W'(spd);
    end

    // Sequencer and ramp state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            fw_reg    <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (tgt_reg == held_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        if (held_reg == '0) begin
                            fw_reg <= 1'b0;
                        end
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    held_reg <= spd;
                    if ((go_up || go_dn) && spd == '0) begin
                        fw_reg <= 1'b0;
                    end
                    if (!(go_up || go_dn) && tgt_reg == '0) begin
                        fw_reg <= 1'b1;
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= last_reg ? ST_IDLE : ST_PLAN;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item and command payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            tgt_reg  <= tgt_sat;
            step_reg <= step_eff;
        end
        if (state_reg == ST_PLAN) begin
            mag_reg  <= spd_abs[MAG_W-1:0];
            neg_reg  <= spd[SPEED_W-1];
            last_reg <= !(go_up || go_dn);
        end
    end

    // Divide unit request, issued while the next speed is being planned.
    assign div_req.start = (state_reg == ST_PLAN);
    assign div_req.mag   = spd_abs[MAG_W-1:0];
    assign div_req.scale = full_scale;

    // Command word: signed velocity from the unsigned quotient.
    assign quot_ext         = {1'b0, div_rsp.quot};
    assign cmd.load         = (state_reg == ST_EMIT) && out_free;
    assign cmd.velocity     = neg_reg ? VEL_W'(-quot_ext) : VEL_W'(quot_ext);
    assign cmd.spread_cycle = (mag_reg > SPREAD_LIMIT);
    assign cmd.freewheel    = fw_reg;
    assign cmd.last         = last_reg;

`ifndef NO_ASSERTIONS
    // The held speed never leaves the saturated range.
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed({held_reg[SPEED_W-1], held_reg}) <= SPEED_MAX) &&
        ($signed({held_reg[SPEED_W-1], held_reg}) >= SPEED_MIN))
        else $error("held speed out of range");

    // The divide unit only finishes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divide result arrived outside the wait state");

    // Once an item is taken, no other is taken until its ramp ends.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !in_ready)
        else $error("ready right after accepting a word");

    // The final command of a ramp returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && last_reg) |=> (state_reg == ST_IDLE))
        else $error("ramp did not end after its final command");
`endif

endmodule
`default_nettype wire

[rtl/core/stepped_speed_ramp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Stepped speed ramp
// Slew-rate limited speed command generator for a stepper driver.
// ----------------------------------------------------------------------------
// Each input word is a target speed in percent, saturated to -100..100. The
// block walks its held speed toward the target in steps of step_size (values
// below 4 act as 4) and emits one command word per step plus a final word at
// the target, marked by m_last; an unchanged target emits nothing. Velocity
// is speed * full_scale / 100, rounded toward zero. Every command goes
// through one shared multiply and divide-by-100 unit, and a command may
// wait for the previous word to be taken on m_ready. The block takes one
// item at a time; s_ready stays low until the final command has been
// loaded into the output register. Configuration is written with
// cfg_wr_en; the user must write it only while the block is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module stepped_speed_ramp (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Configuration write port
    input  wire                                 cfg_wr_en,
    input  wire                                 cfg_index,
    input  wire        [srmp_pkg::FS_W-1:0]     cfg_wdata,
    // Input channel
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire signed [srmp_pkg::SPEED_W-1:0]  s_target_speed,
    // Result channel
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [srmp_pkg::VEL_W-1:0]   m_velocity,
    output logic                                m_spread_cycle,
    output logic                                m_freewheel,
    output logic                                m_last
);
    import srmp_pkg::*;

    logic [STEP_W-1:0] step_size_reg;
    logic [FS_W-1:0]   full_scale_reg;
    logic              m_valid_reg;
    logic [VEL_W-1:0]  velocity_reg;
    logic              spread_reg;
    logic              freewheel_reg;
    logic              last_reg;

    logic              out_free;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    cmd_t              cmd;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= STEP_SIZE_RST;
            full_scale_reg <= FULL_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_SIZE:  step_size_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    srmp_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .target_speed (s_target_speed),
        .step_size    (step_size_reg),
        .full_scale   (full_scale_reg),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_free     (out_free),
        .cmd          (cmd)
    );

    srmp_div100 u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Output register: a new word may load as the current one is taken.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            velocity_reg  <= cmd.velocity;
            spread_reg    <= cmd.spread_cycle;
            freewheel_reg <= cmd.freewheel;
            last_reg      <= cmd.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_velocity     = $signed(velocity_reg);
    assign m_spread_cycle = spread_reg;
    assign m_freewheel    = freewheel_reg;
    assign m_last         = last_reg;

endmodule
`default_nettype wire
